// ===== hdl/fzw_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, field widths, register codes and width helpers for the fractal-Z
// weight address generator. No dependencies.

package fzw_pkg;

	localparam int N_BLOCK_DEF = 16;
	localparam int MAX_DIM_DEF = 16384;

	// Field widths fixed by the item and register formats.
	localparam int C1I_W      = 10;
	localparam int IDX_W      = 14;
	localparam int C0I_W      = 5;
	localparam int CI_W       = 15;
	localparam int OFF_W      = 40;
	localparam int EB_W       = 4;
	localparam int LAYOUT_W   = 2;
	localparam int C0_W       = 6;
	localparam int DIM_REG_W  = 15;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 15;
	localparam int CMP_W      = 16;
	localparam int LATENCY    = 4;

	localparam logic [C0_W-1:0] C0_WIDE_CODE = 6'd32;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LAYOUT_MODE = 3'd0,
		REG_DIM_N       = 3'd1,
		REG_DIM_C       = 3'd2,
		REG_DIM_H       = 3'd3,
		REG_DIM_W       = 3'd4,
		REG_CUBE_C0     = 3'd5,
		REG_ELEM_BYTES  = 3'd6
	} cfg_reg_t;

	typedef enum logic [LAYOUT_W-1:0] {
		LAYOUT_NCHW = 2'd0,
		LAYOUT_HWCN = 2'd1,
		LAYOUT_NHWC = 2'd2
	} layout_t;

	typedef struct packed {
		layout_t          layout;
		logic             c0_wide;
		logic [EB_W-1:0]  elem_bytes;
	} cfg_ctrl_t;

	// Largest dimension a 15-bit register can carry after clamping.
	function automatic int eff_dim(input int max_dim);
		int reg_max;
		reg_max = (1 << DIM_REG_W) - 1;
		return (max_dim < reg_max) ? max_dim : reg_max;
	endfunction

	function automatic int dim_width(input int max_dim);
		return $clog2(eff_dim(max_dim) + 1);
	endfunction

	// Padded kernel count stays below eff + n_block.
	function automatic int np_width(input int max_dim, input int n_block);
		return $clog2(eff_dim(max_dim) + n_block);
	endfunction

	function automatic int c1_width(input int max_dim);
		return $clog2(((eff_dim(max_dim) + 15) >> 4) + 1);
	endfunction

endpackage

// ===== hdl/fzw_mac.sv =====
`timescale 1ns / 1ps
// Multiply-add slice, y = a * m + d taken modulo 2^O_W.
// Purely combinational; no package dependencies.

module fzw_mac #(
	parameter int A_W = 8,
	parameter int M_W = 8,
	parameter int D_W = 8,
	parameter int O_W = 8
) (
	input  logic [A_W-1:0] a,
	input  logic [M_W-1:0] m,
	input  logic [D_W-1:0] d,
	output logic [O_W-1:0] y
);

	localparam int T_W = ((A_W + M_W > D_W) ? (A_W + M_W) : D_W) + 1;
	localparam int W   = (T_W > O_W) ? T_W : O_W;

	logic [W-1:0] sum;

	assign sum = W'(a) * W'(m) + W'(d);
	assign y   = sum[O_W-1:0];

endmodule

// ===== hdl/fzw_cfg.sv =====
`timescale 1ns / 1ps
// Configuration registers with clamped dimensions and derived shape values
// (channel block count and kernel count padded to N_BLOCK). Uses fzw_pkg.

module fzw_cfg #(
	parameter int N_BLOCK = fzw_pkg::N_BLOCK_DEF,
	parameter int MAX_DIM = fzw_pkg::MAX_DIM_DEF
) (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic                                       cfg_wr_en,
	input  logic [fzw_pkg::CFG_IDX_W-1:0]              cfg_index,
	input  logic [fzw_pkg::CFG_DATA_W-1:0]             cfg_wdata,
	output fzw_pkg::cfg_ctrl_t                         ctrl,
	output logic [fzw_pkg::dim_width(MAX_DIM)-1:0]     dim_n,
	output logic [fzw_pkg::dim_width(MAX_DIM)-1:0]     dim_c,
	output logic [fzw_pkg::dim_width(MAX_DIM)-1:0]     dim_h,
	output logic [fzw_pkg::dim_width(MAX_DIM)-1:0]     dim_w,
	output logic [fzw_pkg::c1_width(MAX_DIM)-1:0]      c1,
	output logic [fzw_pkg::np_width(MAX_DIM, N_BLOCK)-1:0] np
);
	import fzw_pkg::*;

	localparam int DIM_W = dim_width(MAX_DIM);
	localparam int C1_W  = c1_width(MAX_DIM);
	localparam int NP_W  = np_width(MAX_DIM, N_BLOCK);
	localparam int CR_W  = DIM_W + 1;

	// Rounded-up kernel blocks via a reciprocal multiply that is exact for x < 2^X_W.
	localparam int X_W   = $clog2(eff_dim(MAX_DIM) + N_BLOCK);
	localparam int L_W   = $clog2(N_BLOCK);
	localparam int SHIFT = X_W + L_W;
	localparam int RECIP = ((1 << SHIFT) + N_BLOCK - 1) / N_BLOCK;
	localparam int R_W   = X_W + 1;
	localparam int P_W   = X_W + R_W;
	localparam int Q_W   = X_W - L_W + 1;

	logic [LAYOUT_W-1:0]  layout_q;
	logic                 c0_wide_q;
	logic [EB_W-1:0]      elem_bytes_q;
	logic [DIM_REG_W-1:0] dim_n_q;
	logic [DIM_REG_W-1:0] dim_c_q;
	logic [DIM_REG_W-1:0] dim_h_q;
	logic [DIM_REG_W-1:0] dim_w_q;
	logic [Q_W-1:0]       nblk_q;
	logic [NP_W-1:0]      np_q;
	logic [X_W-1:0]       n_round;
	logic [P_W-1:0]       recip_prod;
	logic [CR_W-1:0]      c_round;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			layout_q     <= LAYOUT_NCHW;
			c0_wide_q    <= 1'b0;
			elem_bytes_q <= EB_W'(2);
			dim_n_q      <= DIM_REG_W'(1);
			dim_c_q      <= DIM_REG_W'(1);
			dim_h_q      <= DIM_REG_W'(1);
			dim_w_q      <= DIM_REG_W'(1);
		end else if (cfg_wr_en) begin
			case (cfg_reg_t'(cfg_index))
				REG_LAYOUT_MODE: layout_q     <= cfg_wdata[LAYOUT_W-1:0];
				REG_DIM_N:       dim_n_q      <= cfg_wdata[DIM_REG_W-1:0];
				REG_DIM_C:       dim_c_q      <= cfg_wdata[DIM_REG_W-1:0];
				REG_DIM_H:       dim_h_q      <= cfg_wdata[DIM_REG_W-1:0];
				REG_DIM_W:       dim_w_q      <= cfg_wdata[DIM_REG_W-1:0];
				REG_CUBE_C0:     c0_wide_q    <= (cfg_wdata[C0_W-1:0] == C0_WIDE_CODE);
				REG_ELEM_BYTES:  elem_bytes_q <= cfg_wdata[EB_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		dim_n = (32'(dim_n_q) > MAX_DIM) ? DIM_W'(MAX_DIM) : DIM_W'(dim_n_q);
		dim_c = (32'(dim_c_q) > MAX_DIM) ? DIM_W'(MAX_DIM) : DIM_W'(dim_c_q);
		dim_h = (32'(dim_h_q) > MAX_DIM) ? DIM_W'(MAX_DIM) : DIM_W'(dim_h_q);
		dim_w = (32'(dim_w_q) > MAX_DIM) ? DIM_W'(MAX_DIM) : DIM_W'(dim_w_q);
	end

	// C1 is a shift because C0 is a power of two.
	assign c_round = CR_W'(dim_c) + (c0_wide_q ? CR_W'(31) : CR_W'(15));
	assign c1      = c0_wide_q ? C1_W'(c_round >> 5) : C1_W'(c_round >> 4);

	assign n_round    = X_W'(dim_n) + X_W'(N_BLOCK - 1);
	assign recip_prod = P_W'(n_round) * P_W'(RECIP);

	// Two register steps; the padded count is first read at the third pipeline stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nblk_q <= Q_W'(1);
			np_q   <= NP_W'(N_BLOCK);
		end else begin
			nblk_q <= recip_prod[SHIFT +: Q_W];
			np_q   <= NP_W'(nblk_q * N_BLOCK);
		end
	end

	assign np = np_q;

	assign ctrl.layout     = layout_t'(layout_q);
	assign ctrl.c0_wide    = c0_wide_q;
	assign ctrl.elem_bytes = elem_bytes_q;

endmodule

// ===== hdl/fractal_z_weight_layout_address_gen_core.sv =====
`timescale 1ns / 1ps
// Fractal-Z weight layout address generator, top level. Uses fzw_pkg, fzw_cfg, fzw_mac.
// An accepted item moves through the valid registers v_s1 to v_s4; done is driven by v_s4.
// One item per cycle while busy is low; four multiply-add stages per offset set the depth.
// busy is high only during reset and the first cycle after it; results cannot be stalled.
// Reset clears all configuration registers to their defaults and empties the pipeline.

module fractal_z_weight_layout_address_gen_core #(
	parameter int N_BLOCK = fzw_pkg::N_BLOCK_DEF,
	parameter int MAX_DIM = fzw_pkg::MAX_DIM_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic [fzw_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [fzw_pkg::CFG_DATA_W-1:0]    cfg_wdata,
	input  logic                              start,
	output logic                              busy,
	input  logic [fzw_pkg::C1I_W-1:0]         chan_block_index,
	input  logic [fzw_pkg::IDX_W-1:0]         row_index,
	input  logic [fzw_pkg::IDX_W-1:0]         col_index,
	input  logic [fzw_pkg::IDX_W-1:0]         kernel_index,
	input  logic [fzw_pkg::C0I_W-1:0]         chan_sub_index,
	output logic                              done,
	output logic [fzw_pkg::OFF_W-1:0]         dst_byte_offset,
	output logic [fzw_pkg::OFF_W-1:0]         src_byte_offset,
	output logic                              zero_fill,
	output logic                              coord_invalid
);
	import fzw_pkg::*;

	localparam int DIM_W = dim_width(MAX_DIM);
	localparam int C1_W  = c1_width(MAX_DIM);
	localparam int NP_W  = np_width(MAX_DIM, N_BLOCK);
	localparam int S1_W  = IDX_W + DIM_W + 1;

	cfg_ctrl_t          ctrl;
	logic [DIM_W-1:0]   dim_n, dim_c, dim_h, dim_w;
	logic [C1_W-1:0]    c1;
	logic [NP_W-1:0]    np;

	fzw_cfg #(
		.N_BLOCK (N_BLOCK),
		.MAX_DIM (MAX_DIM)
	) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.ctrl      (ctrl),
		.dim_n     (dim_n),
		.dim_c     (dim_c),
		.dim_h     (dim_h),
		.dim_w     (dim_w),
		.c1        (c1),
		.np        (np)
	);

	logic busy_q;
	logic accept;
	logic v_s1, v_s2, v_s3, v_s4;

	assign busy   = busy_q;
	assign accept = start && !busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			v_s4   <= 1'b0;
		end else begin
			busy_q <= 1'b0;
			v_s1   <= accept;
			v_s2   <= v_s1;
			v_s3   <= v_s2;
			v_s4   <= v_s3;
		end
	end

	// Stage 0: coordinate checks that do not need the padded kernel count.
	logic [CI_W-1:0] ci_d;
	logic            inv_d;
	logic            padc_d;

	assign ci_d = (ctrl.c0_wide ? CI_W'({chan_block_index, 5'b0})
	                            : CI_W'({chan_block_index, 4'b0})) + CI_W'(chan_sub_index);

	assign inv_d = (CMP_W'(chan_block_index) >= CMP_W'(c1))
	            || (CMP_W'(row_index) >= CMP_W'(dim_h))
	            || (CMP_W'(col_index) >= CMP_W'(dim_w))
	            || (chan_sub_index[C0I_W-1] && !ctrl.c0_wide);

	assign padc_d = CMP_W'(ci_d) >= CMP_W'(dim_c);

	// Source index operands for each layout, one set for each of the first three multiply-add stages.
	logic [IDX_W-1:0] src_a1;
	logic [DIM_W-1:0] src_m1, src_m2, src_m3;
	logic [CI_W-1:0]  src_b1, src_d2, src_e3;

	logic [IDX_W-1:0] hi_s1, wi_s1, ni_s1, wi_s2, ni_s2;
	logic [CI_W-1:0]  ci_s1, ci_s2;
	logic [C0I_W-1:0] c0i_s1, c0i_s2, c0i_s3;

	always_comb begin
		case (ctrl.layout)
			LAYOUT_HWCN: begin
				src_a1 = row_index;
				src_m1 = dim_w;
				src_b1 = CI_W'(col_index);
				src_m2 = dim_c;
				src_d2 = ci_s1;
				src_m3 = dim_n;
				src_e3 = CI_W'(ni_s2);
			end
			LAYOUT_NHWC: begin
				src_a1 = kernel_index;
				src_m1 = dim_h;
				src_b1 = CI_W'(row_index);
				src_m2 = dim_w;
				src_d2 = CI_W'(wi_s1);
				src_m3 = dim_c;
				src_e3 = ci_s2;
			end
			default: begin
				// NCHW, and the reserved code behaves the same way.
				src_a1 = kernel_index;
				src_m1 = dim_c;
				src_b1 = ci_d;
				src_m2 = dim_h;
				src_d2 = CI_W'(hi_s1);
				src_m3 = dim_w;
				src_e3 = CI_W'(wi_s2);
			end
		endcase
	end

	// Stage 1
	logic [S1_W-1:0]  dst1_d, src1_d, dst_s1, src_s1;
	logic             inv_s1, padc_s1;

	fzw_mac #(.A_W(C1I_W), .M_W(DIM_W), .D_W(IDX_W), .O_W(S1_W)) u_dst1 (
		.a (chan_block_index), .m (dim_h), .d (row_index), .y (dst1_d)
	);
	fzw_mac #(.A_W(IDX_W), .M_W(DIM_W), .D_W(CI_W), .O_W(S1_W)) u_src1 (
		.a (src_a1), .m (src_m1), .d (src_b1), .y (src1_d)
	);

	always_ff @(posedge clk) begin
		dst_s1  <= dst1_d;
		src_s1  <= src1_d;
		inv_s1  <= inv_d;
		padc_s1 <= padc_d;
		hi_s1   <= row_index;
		wi_s1   <= col_index;
		ni_s1   <= kernel_index;
		ci_s1   <= ci_d;
		c0i_s1  <= chan_sub_index;
	end

	// Stage 2
	logic [OFF_W-1:0] dst2_d, src2_d, dst_s2, src_s2;
	logic             inv_s2, padc_s2;

	fzw_mac #(.A_W(S1_W), .M_W(DIM_W), .D_W(IDX_W), .O_W(OFF_W)) u_dst2 (
		.a (dst_s1), .m (dim_w), .d (wi_s1), .y (dst2_d)
	);
	fzw_mac #(.A_W(S1_W), .M_W(DIM_W), .D_W(CI_W), .O_W(OFF_W)) u_src2 (
		.a (src_s1), .m (src_m2), .d (src_d2), .y (src2_d)
	);

	always_ff @(posedge clk) begin
		dst_s2  <= dst2_d;
		src_s2  <= src2_d;
		inv_s2  <= inv_s1;
		padc_s2 <= padc_s1;
		wi_s2   <= wi_s1;
		ni_s2   <= ni_s1;
		ci_s2   <= ci_s1;
		c0i_s2  <= c0i_s1;
	end

	// Stage 3: the kernel-index checks sit here, where the padded count is settled.
	logic [OFF_W-1:0] dst3_d, src3_d, dst_s3, src_s3;
	logic             inv_s3, pad_s3;

	fzw_mac #(.A_W(OFF_W), .M_W(NP_W), .D_W(IDX_W), .O_W(OFF_W)) u_dst3 (
		.a (dst_s2), .m (np), .d (ni_s2), .y (dst3_d)
	);
	fzw_mac #(.A_W(OFF_W), .M_W(DIM_W), .D_W(CI_W), .O_W(OFF_W)) u_src3 (
		.a (src_s2), .m (src_m3), .d (src_e3), .y (src3_d)
	);

	always_ff @(posedge clk) begin
		dst_s3 <= dst3_d;
		src_s3 <= src3_d;
		inv_s3 <= inv_s2 || (CMP_W'(ni_s2) >= CMP_W'(np));
		pad_s3 <= padc_s2 || (CMP_W'(ni_s2) >= CMP_W'(dim_n));
		c0i_s3 <= c0i_s2;
	end

	// Stage 4: fold in C0, scale to bytes and zero what the flags call for.
	logic [OFF_W-1:0] dst_pre, dst4_d, src4_d;
	logic [OFF_W-1:0] dst_s4, src_s4;
	logic             inv_s4, pad_s4;

	assign dst_pre = (ctrl.c0_wide ? {dst_s3[OFF_W-6:0], 5'b0} : {dst_s3[OFF_W-5:0], 4'b0})
	               + OFF_W'(c0i_s3);

	fzw_mac #(.A_W(OFF_W), .M_W(EB_W), .D_W(1), .O_W(OFF_W)) u_dst4 (
		.a (dst_pre), .m (ctrl.elem_bytes), .d (1'b0), .y (dst4_d)
	);
	fzw_mac #(.A_W(OFF_W), .M_W(EB_W), .D_W(1), .O_W(OFF_W)) u_src4 (
		.a (src_s3), .m (ctrl.elem_bytes), .d (1'b0), .y (src4_d)
	);

	always_ff @(posedge clk) begin
		dst_s4 <= inv_s3 ? '0 : dst4_d;
		src_s4 <= (inv_s3 || pad_s3) ? '0 : src4_d;
		pad_s4 <= pad_s3 && !inv_s3;
		inv_s4 <= inv_s3;
	end

	assign done            = v_s4;
	assign dst_byte_offset = dst_s4;
	assign src_byte_offset = src_s4;
	assign zero_fill       = pad_s4;
	assign coord_invalid   = inv_s4;

endmodule

// ===== hdl/fzw_chk.sv =====
`timescale 1ns / 1ps
// Port-level checks for the fractal-Z address generator, bound to the top level.
// Uses fzw_pkg for widths and the pipeline latency.

module fzw_chk (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      start,
	input logic                      busy,
	input logic                      done,
	input logic [fzw_pkg::OFF_W-1:0] dst_byte_offset,
	input logic [fzw_pkg::OFF_W-1:0] src_byte_offset,
	input logic                      zero_fill,
	input logic                      coord_invalid
);
	import fzw_pkg::*;

	// Every result strobe traces back to exactly one accepted item.
	a_done_has_item: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LATENCY))
		else $error("result strobe without an accepted item");

	// No accepted item is dropped.
	a_item_gives_done: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LATENCY done)
		else $error("accepted item produced no result");

	// An out-of-range coordinate carries no offsets and no pad flag.
	a_invalid_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(done && coord_invalid) |-> (dst_byte_offset == '0 && src_byte_offset == '0
			&& !zero_fill))
		else $error("invalid coordinate with nonzero result fields");

	// A padded element never points into the source.
	a_pad_no_src: assert property (@(posedge clk) disable iff (!arst_n)
		(done && zero_fill) |-> (src_byte_offset == '0))
		else $error("padded element with a source offset");

endmodule

bind fractal_z_weight_layout_address_gen_core fzw_chk u_chk (.*);
